@@ rtl/bounded_linked_list_engine_top_assert.svh @@
// Assertion macros used by the linked list engine checker.
`ifndef BOUNDED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BLL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("linked list engine check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BLL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("linked list engine check failed");

`endif

@@ rtl/bll_pkg.sv @@
// Package: widths, codes, state and result types of the linked list engine.
`timescale 1ns / 1ps

package bll_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    F_READ     = 3'd0,
    F_INS_HEAD = 3'd1,
    F_INS_TAIL = 3'd2,
    F_REMOVE   = 3'd3,
    F_DUMP     = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_VAL,
    S_INS,
    S_RM_HEAD,
    S_RM_SLOT,
    S_RM_NEXT,
    S_DUMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic                     last;
  } result_t;

endpackage

@@ rtl/bll_in_if.sv @@
// Request channel: operation, index and value with valid/ready.
`timescale 1ns / 1ps

interface bll_in_if import bll_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

@@ rtl/bll_out_if.sv @@
// Result channel: data, status and last flag with valid/ready.
`timescale 1ns / 1ps

interface bll_out_if import bll_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, data, status, last, input ready);
  modport sink   (input valid, data, status, last, output ready);
endinterface

@@ rtl/bounded_linked_list_engine_top.sv @@
// Linked list engine of signed 32-bit values: request and result channels.
//
// Requests on in_i carry func (read, insert head, insert tail, remove, dump),
// index and value; results on out_o carry data, status and last.
// One request is worked at a time; in_i.ready is high while the engine idles,
// also while a finished result still waits in the output register.
// Sequencer states that a request passes through after idle:
//   read:   S_VAL at index 0, otherwise S_WALK over the links, then S_VAL
//   insert: S_INS, which links in the popped free slot
//   remove: S_RM_HEAD at index 0, otherwise S_RM_SLOT then S_RM_NEXT,
//           preceded by S_WALK beyond index 1
//   dump:   S_DUMP, one value per cycle while the output register is free
//   refused or empty requests: S_RESP
// The walk runs one node per cycle, set by the registered read of the link memory feeding its own next address.
// Reset empties the list and marks every slot free; no clearing pass.
// With the output register full and out_o.ready low, emitting states hold,
// memory read data included, and resume once the output register drains.
`timescale 1ns / 1ps

module bounded_linked_list_engine_top import bll_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bll_in_if.sink       in_i,
  bll_out_if.source    out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                emit_valid;
  result_t             emit;
  result_t             res;
  logic                out_free;

  logic                val_re, val_we;
  logic [AW-1:0]       val_raddr, val_waddr;
  logic [DATA_W-1:0]   val_rdata, val_wdata;
  logic                lnk_re, lnk_we;
  logic [AW-1:0]       lnk_raddr, lnk_waddr, lnk_rdata, lnk_wdata;
  logic                push, pop_rd;
  logic [AW-1:0]       push_addr, push_slot, pop_addr, pop_slot;

  bll_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_func_i    (in_i.func),
    .in_index_i   (in_i.index),
    .in_value_i   (in_i.value),
    .in_ready_o   (in_i.ready),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .out_free_i   (out_free),
    .val_re_o     (val_re),
    .val_raddr_o  (val_raddr),
    .val_rdata_i  (val_rdata),
    .val_we_o     (val_we),
    .val_waddr_o  (val_waddr),
    .val_wdata_o  (val_wdata),
    .lnk_re_o     (lnk_re),
    .lnk_raddr_o  (lnk_raddr),
    .lnk_rdata_i  (lnk_rdata),
    .lnk_we_o     (lnk_we),
    .lnk_waddr_o  (lnk_waddr),
    .lnk_wdata_o  (lnk_wdata),
    .push_o       (push),
    .push_addr_o  (push_addr),
    .push_slot_o  (push_slot),
    .pop_rd_o     (pop_rd),
    .pop_addr_o   (pop_addr),
    .pop_slot_i   (pop_slot)
  );

  bll_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  bll_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  bll_free_stack #(
    .CAPACITY (CAPACITY)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_addr_i (push_addr),
    .push_slot_i (push_slot),
    .pop_rd_i    (pop_rd),
    .pop_addr_i  (pop_addr),
    .pop_slot_o  (pop_slot)
  );

  bll_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_i       (emit),
    .free_o       (out_free),
    .valid_o      (out_o.valid),
    .ready_i      (out_o.ready),
    .res_o        (res)
  );

  assign out_o.data   = res.data;
  assign out_o.status = res.status;
  assign out_o.last   = res.last;

endmodule

@@ rtl/bll_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bll_free_stack.sv @@
// Free slot stack: RAM of released slots plus per-entry written flags.
`timescale 1ns / 1ps

module bll_free_stack import bll_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [AW-1:0] push_addr_i,
  input  logic [AW-1:0] push_slot_i,
  input  logic          pop_rd_i,
  input  logic [AW-1:0] pop_addr_i,
  output logic [AW-1:0] pop_slot_o
);

  logic [CAPACITY-1:0] vld_q;
  logic [CAPACITY-1:0] vld_d;
  logic [AW-1:0]       pop_addr_q;
  logic [AW-1:0]       ram_rdata;

  bll_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (push_addr_i),
    .wdata_i (push_slot_i),
    .re_i    (pop_rd_i),
    .raddr_i (pop_addr_i),
    .rdata_o (ram_rdata)
  );

  // Mark an entry once it has been written
  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d[push_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Track the address of the pending read
  always_ff @(posedge clk_i) begin
    if (pop_rd_i) begin
      pop_addr_q <= pop_addr_i;
    end
  end

  // An entry never written still holds its own index
  assign pop_slot_o = vld_q[pop_addr_q] ? ram_rdata : pop_addr_q;

endmodule

@@ rtl/bll_out_stage.sv @@
// Output register that decouples the result channel from the sequencer.
`timescale 1ns / 1ps

module bll_out_stage import bll_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    emit_valid_i,
  input  result_t emit_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  // Load a new result or drop the one just taken
  always_comb begin
    valid_d = valid_q;
    if (emit_valid_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid_i) begin
      res_q <= emit_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ rtl/bll_ctrl.sv @@
// Sequencer: list registers, link walk and read-modify-write of node memories.
`timescale 1ns / 1ps

module bll_ctrl import bll_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY),
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request side
  input  logic                     in_valid_i,
  input  logic [FUNC_W-1:0]        in_func_i,
  input  logic [IDX_W-1:0]         in_index_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  output logic                     in_ready_o,
  // result side
  output logic                     emit_valid_o,
  output result_t                  emit_o,
  input  logic                     out_free_i,
  // node value memory
  output logic                     val_re_o,
  output logic [AW-1:0]            val_raddr_o,
  input  logic [DATA_W-1:0]        val_rdata_i,
  output logic                     val_we_o,
  output logic [AW-1:0]            val_waddr_o,
  output logic [DATA_W-1:0]        val_wdata_o,
  // node link memory
  output logic                     lnk_re_o,
  output logic [AW-1:0]            lnk_raddr_o,
  input  logic [AW-1:0]            lnk_rdata_i,
  output logic                     lnk_we_o,
  output logic [AW-1:0]            lnk_waddr_o,
  output logic [AW-1:0]            lnk_wdata_o,
  // free slot stack
  output logic                     push_o,
  output logic [AW-1:0]            push_addr_o,
  output logic [AW-1:0]            push_slot_o,
  output logic                     pop_rd_o,
  output logic [AW-1:0]            pop_addr_o,
  input  logic [AW-1:0]            pop_slot_i
);

  localparam int unsigned NW = (IDX_W > CW) ? IDX_W : CW;

  state_e                   state_q, state_d;
  func_e                    op_q, op_d;
  status_e                  rsp_q, rsp_d;
  logic [NW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            tgt_q, tgt_d;
  logic [AW-1:0]            slot_q, slot_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     tail_flag_q, tail_flag_d;
  logic [AW-1:0]            head_q, head_d;
  logic [AW-1:0]            tail_q, tail_d;
  logic [CW-1:0]            count_q, count_d;

  logic [CW-1:0] free_cnt;
  logic [NW-1:0] idx_n;
  logic [NW-1:0] cnt_n;
  logic          full;

  assign free_cnt    = CW'(CAPACITY) - count_q;
  assign idx_n       = NW'(in_index_i);
  assign cnt_n       = NW'(count_q);
  assign full        = (count_q == CW'(CAPACITY));
  assign pop_addr_o  = AW'(free_cnt - CW'(1));
  assign push_addr_o = AW'(free_cnt);

  // Next state, memory requests and result emission
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rsp_d       = rsp_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    slot_d      = slot_q;
    value_d     = value_q;
    tail_flag_d = tail_flag_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;

    in_ready_o   = 1'b0;
    emit_valid_o = 1'b0;
    emit_o       = '{data: '0, status: ST_OK, last: 1'b1};

    val_re_o    = 1'b0;
    val_raddr_o = head_q;
    val_we_o    = 1'b0;
    val_waddr_o = pop_slot_i;
    val_wdata_o = value_q;
    lnk_re_o    = 1'b0;
    lnk_raddr_o = head_q;
    lnk_we_o    = 1'b0;
    lnk_waddr_o = pop_slot_i;
    lnk_wdata_o = head_q;
    push_o      = 1'b0;
    push_slot_o = tgt_q;
    pop_rd_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          value_d     = in_value_i;
          tail_flag_d = (idx_n + NW'(1) == cnt_n);
          unique case (in_func_i) inside
            F_READ: begin
              op_d = F_READ;
              if (idx_n >= cnt_n) begin
                rsp_d   = ST_RANGE;
                state_d = S_RESP;
              end else if (in_index_i == '0) begin
                val_re_o = 1'b1;
                state_d  = S_VAL;
              end else begin
                lnk_re_o = 1'b1;
                cnt_d    = idx_n;
                state_d  = S_WALK;
              end
            end
            F_INS_HEAD, F_INS_TAIL: begin
              op_d = func_e'(in_func_i);
              if (full) begin
                rsp_d   = ST_FULL;
                state_d = S_RESP;
              end else begin
                pop_rd_o = 1'b1;
                state_d  = S_INS;
              end
            end
            F_REMOVE: begin
              op_d = F_REMOVE;
              if (idx_n >= cnt_n) begin
                rsp_d   = ST_RANGE;
                state_d = S_RESP;
              end else if (in_index_i == '0) begin
                lnk_re_o = 1'b1;
                tgt_d    = head_q;
                state_d  = S_RM_HEAD;
              end else if (idx_n == NW'(1)) begin
                lnk_re_o = 1'b1;
                tgt_d    = head_q;
                state_d  = S_RM_SLOT;
              end else begin
                lnk_re_o = 1'b1;
                cnt_d    = idx_n - NW'(1);
                state_d  = S_WALK;
              end
            end
            F_DUMP: begin
              op_d = F_DUMP;
              if (count_q == '0) begin
                rsp_d   = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                val_re_o = 1'b1;
                lnk_re_o = 1'b1;
                cnt_d    = cnt_n;
                state_d  = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end

      // Follow one link per cycle until the target slot is reached
      S_WALK: begin
        lnk_raddr_o = lnk_rdata_i;
        val_raddr_o = lnk_rdata_i;
        if (cnt_q == NW'(1)) begin
          if (op_q == F_READ) begin
            val_re_o = 1'b1;
            state_d  = S_VAL;
          end else begin
            lnk_re_o = 1'b1;
            tgt_d    = lnk_rdata_i;
            state_d  = S_RM_SLOT;
          end
        end else begin
          lnk_re_o = 1'b1;
          cnt_d    = cnt_q - NW'(1);
        end
      end

      S_VAL: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          emit_o.data  = val_rdata_i;
          state_d      = S_IDLE;
        end
      end

      // Link the popped slot in at the head or the tail
      S_INS: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          val_we_o     = 1'b1;
          count_d      = count_q + CW'(1);
          if (op_q == F_INS_HEAD) begin
            lnk_we_o = 1'b1;
            head_d   = pop_slot_i;
            if (count_q == '0) begin
              tail_d = pop_slot_i;
            end
          end else begin
            if (count_q == '0) begin
              head_d = pop_slot_i;
            end else begin
              lnk_we_o    = 1'b1;
              lnk_waddr_o = tail_q;
              lnk_wdata_o = pop_slot_i;
            end
            tail_d = pop_slot_i;
          end
          state_d = S_IDLE;
        end
      end

      // Unlink the head node and release its slot
      S_RM_HEAD: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          head_d       = lnk_rdata_i;
          push_o       = 1'b1;
          count_d      = count_q - CW'(1);
          state_d      = S_IDLE;
        end
      end

      // Predecessor's link gives the victim; fetch the victim's link
      S_RM_SLOT: begin
        slot_d      = lnk_rdata_i;
        lnk_re_o    = 1'b1;
        lnk_raddr_o = lnk_rdata_i;
        state_d     = S_RM_NEXT;
      end

      // Bridge the predecessor over the victim and release the victim
      S_RM_NEXT: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          lnk_we_o     = 1'b1;
          lnk_waddr_o  = tgt_q;
          lnk_wdata_o  = lnk_rdata_i;
          push_o       = 1'b1;
          push_slot_o  = slot_q;
          count_d      = count_q - CW'(1);
          if (tail_flag_q) begin
            tail_d = tgt_q;
          end
          state_d = S_IDLE;
        end
      end

      // Stream values while following links; hold when the output is busy
      S_DUMP: begin
        val_raddr_o = lnk_rdata_i;
        lnk_raddr_o = lnk_rdata_i;
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          emit_o.data  = val_rdata_i;
          emit_o.last  = (cnt_q == NW'(1));
          if (cnt_q == NW'(1)) begin
            state_d = S_IDLE;
          end else begin
            val_re_o = 1'b1;
            lnk_re_o = 1'b1;
            cnt_d    = cnt_q - NW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free_i) begin
          emit_valid_o  = 1'b1;
          emit_o.data   = (op_q == F_READ) ? '1 : '0;
          emit_o.status = rsp_q;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Per-request working registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    rsp_q       <= rsp_d;
    cnt_q       <= cnt_d;
    tgt_q       <= tgt_d;
    slot_q      <= slot_d;
    value_q     <= value_d;
    tail_flag_q <= tail_flag_d;
  end

endmodule

@@ rtl/bll_checker.sv @@
// Port-level checks of the linked list engine, bound to the top level.
`timescale 1ns / 1ps

`include "bounded_linked_list_engine_top_assert.svh"

module bll_checker import bll_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] out_data_i,
  input logic [STATUS_W-1:0]      out_status_i,
  input logic                     out_last_i
);

  // A stalled result holds
  `BLL_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({out_data_i, out_status_i, out_last_i}))

  // Any refusal or miss is a single, final result
  `BLL_ASSERT_NOW(a_err_last, out_valid_i && (out_status_i != ST_OK), out_last_i)

  // Full and empty results carry zero data
  `BLL_ASSERT_NOW(a_err_data, out_valid_i && (out_status_i == ST_FULL || out_status_i == ST_EMPTY), out_data_i == '0)

  // No new request is taken in the middle of a dump
  `BLL_ASSERT_NOW(a_dump_busy, out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind bounded_linked_list_engine_top bll_checker u_bll_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);
